// ----- design/sscheck_pkg.sv -----
// ----------------------------------------------------------------------------
// sscheck_pkg
// Shared types, codes and helpers for the sensor scratchpad checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sscheck_pkg;

    localparam int FRAME_BYTES_DEFAULT = 9;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] CRC_POLY    = 8'h8C;
    localparam logic [7:0] CFG_KEEP    = 8'h9F;
    localparam int         CFG_RES_LSB = 5;

    localparam logic CMD_PRESENCE = 1'b0;
    localparam logic CMD_BYTE     = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_CRC_BAD   = 2'd1;
    localparam logic [1:0] STATUS_NO_SENSOR = 2'd2;

    localparam logic [1:0] SCALE_CELSIUS    = 2'd0;
    localparam logic [1:0] SCALE_FAHRENHEIT = 2'd1;
    localparam logic [1:0] SCALE_KELVIN     = 2'd2;

    localparam logic       REG_TEMP_SCALE = 1'b0;
    localparam logic       REG_RESOLUTION = 1'b1;
    localparam logic [1:0] RESOLUTION_RESET = 2'd3;

    localparam logic [5:0] MULT_CENTI_C = 6'd25;
    localparam logic [5:0] MULT_CENTI_F = 6'd45;
    localparam logic signed [19:0] OFFSET_F = 20'sd3200;
    localparam logic signed [19:0] OFFSET_K = 20'sd27315;

    localparam logic [9:0] DELAY_MS [4] = '{10'd94, 10'd188, 10'd375, 10'd750};

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       sensor_present;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [19:0] temperature_centi;
        logic signed [15:0] raw_temperature;
        logic [7:0]         alarm_high;
        logic [7:0]         alarm_low;
        logic [7:0]         config_writeback;
        logic [9:0]         conversion_delay_ms;
        logic [7:0]         computed_crc;
    } out_item_t;

    typedef struct packed {
        logic [1:0] temp_scale;
        logic [1:0] resolution_select;
    } cfg_t;

    typedef struct packed {
        logic               no_sensor;
        logic               crc_ok;
        logic signed [15:0] raw;
        logic [7:0]         alarm_high;
        logic [7:0]         alarm_low;
        logic [7:0]         config_hold;
        logic [7:0]         crc;
    } job_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        logic       mix;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ b[i];
            c   = {1'b0, c[7:1]};
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/sensor_scratchpad_checker.sv -----
// ----------------------------------------------------------------------------
// sensor_scratchpad_checker
// Checks one-wire temperature scratchpad frames and converts the reading.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_item_t
//   out      output     out_valid / out_ready  out_item_t
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// One item per cycle is accepted while the job queue has room.
// A result for the item that ends a frame or reports no sensor passes through
// the job queue and then the output register.
// A stalled output fills the queue, then in_ready drops.
// Reset clears the frame counter, CRC, queue and output valid; scale resets to
// Celsius and resolution to 12 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_scratchpad_checker #(
    parameter int FRAME_BYTES = sscheck_pkg::FRAME_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH = sscheck_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire sscheck_pkg::in_item_t  in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output sscheck_pkg::out_item_t      out_data,
    input  wire logic                   cfg_write,
    input  wire logic                   cfg_index,
    input  wire logic [1:0]             cfg_data
);

    sscheck_pkg::cfg_t cfg_reg;
    sscheck_pkg::job_t push_job;
    sscheck_pkg::job_t head_job;
    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_scale        <= sscheck_pkg::SCALE_CELSIUS;
            cfg_reg.resolution_select <= sscheck_pkg::RESOLUTION_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sscheck_pkg::REG_TEMP_SCALE: cfg_reg.temp_scale        <= cfg_data;
                sscheck_pkg::REG_RESOLUTION: cfg_reg.resolution_select <= cfg_data;
            endcase
        end
    end

    sscheck_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    sscheck_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push),
        .wr_data   (push_job),
        .full      (queue_full),
        .rd_en     (pop),
        .not_empty (queue_valid),
        .rd_data   (head_job)
    );

    sscheck_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (queue_valid),
        .job       (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- design/sscheck_fifo.sv -----
// ----------------------------------------------------------------------------
// sscheck_fifo
// Short job queue between the frame front end and the conversion back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sscheck_fifo #(
    parameter int DEPTH = sscheck_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire sscheck_pkg::job_t wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output logic                   not_empty,
    output sscheck_pkg::job_t      rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sscheck_pkg::job_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/sscheck_front.sv -----
// ----------------------------------------------------------------------------
// sscheck_front
// Accepts presence reports and scratchpad bytes, runs the CRC and queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module sscheck_front #(
    parameter int FRAME_BYTES = sscheck_pkg::FRAME_BYTES_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire sscheck_pkg::in_item_t in_data,
    input  wire logic                  queue_full,
    output logic                       push,
    output sscheck_pkg::job_t          job
);

    localparam int IW = $clog2(FRAME_BYTES);
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_BYTES - 1);

    logic [IW-1:0] idx_reg, idx_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    temp_low_reg, temp_high_reg;
    logic [7:0]    alarm_high_reg, alarm_low_reg, config_reg;
    logic          accept;
    logic          is_byte;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign is_byte  = (in_data.command == sscheck_pkg::CMD_BYTE);

    assign push = accept && (is_byte ? (idx_reg == LAST_IDX) : !in_data.sensor_present);

    always_comb
    begin
        job             = '0;
        job.no_sensor   = !is_byte;
        if (is_byte)
        begin
            job.crc_ok     = (crc_reg == in_data.data_byte);
            job.raw        = {temp_high_reg, temp_low_reg};
            job.alarm_high = alarm_high_reg;
            job.alarm_low  = alarm_low_reg;
            job.config_hold = config_reg;
            job.crc        = crc_reg;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        if (accept)
        begin
            if (!is_byte || idx_reg == LAST_IDX)
            begin
                idx_next = '0;
                crc_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                crc_next = sscheck_pkg::crc8_byte(crc_reg, in_data.data_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            crc_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_byte)
        begin
            unique case (idx_reg)
                IW'(0): temp_low_reg   <= in_data.data_byte;
                IW'(1): temp_high_reg  <= in_data.data_byte;
                IW'(2): alarm_high_reg <= in_data.data_byte;
                IW'(3): alarm_low_reg  <= in_data.data_byte;
                IW'(4): config_reg     <= in_data.data_byte;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/sscheck_back.sv -----
// ----------------------------------------------------------------------------
// sscheck_back
// Converts queued jobs into result items and holds them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sscheck_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sscheck_pkg::cfg_t cfg,
    input  wire logic              job_valid,
    input  wire sscheck_pkg::job_t job,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sscheck_pkg::out_item_t out_data
);

    logic                   out_valid_reg;
    sscheck_pkg::out_item_t out_data_reg;
    sscheck_pkg::out_item_t result;
    logic [5:0]             mult;
    logic signed [19:0]     offset;
    logic signed [21:0]     prod;
    logic signed [21:0]     quarter;
    logic [9:0]             delay;

    assign pop       = job_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign delay     = sscheck_pkg::DELAY_MS[cfg.resolution_select];

    always_comb
    begin
        unique case (cfg.temp_scale)
            sscheck_pkg::SCALE_FAHRENHEIT:
            begin
                mult   = sscheck_pkg::MULT_CENTI_F;
                offset = sscheck_pkg::OFFSET_F;
            end
            sscheck_pkg::SCALE_KELVIN:
            begin
                mult   = sscheck_pkg::MULT_CENTI_C;
                offset = sscheck_pkg::OFFSET_K;
            end
            default:
            begin
                mult   = sscheck_pkg::MULT_CENTI_C;
                offset = '0;
            end
        endcase
    end

    // arithmetic shift gives floor division by four
    assign prod    = $signed(job.raw) * $signed({1'b0, mult});
    assign quarter = prod >>> 2;

    always_comb
    begin
        result                     = '0;
        result.conversion_delay_ms = delay;
        if (job.no_sensor)
        begin
            result.status = sscheck_pkg::STATUS_NO_SENSOR;
        end
        else
        begin
            result.status            = job.crc_ok ? sscheck_pkg::STATUS_OK
                                                  : sscheck_pkg::STATUS_CRC_BAD;
            result.temperature_centi = job.crc_ok ? (quarter[19:0] + offset) : '0;
            result.raw_temperature   = job.raw;
            result.alarm_high        = job.alarm_high;
            result.alarm_low         = job.alarm_low;
            result.config_writeback  = (job.config_hold & sscheck_pkg::CFG_KEEP)
                                     | ({6'd0, cfg.resolution_select} << sscheck_pkg::CFG_RES_LSB);
            result.computed_crc      = job.crc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ----- design/sscheck_checker.sv -----
// ----------------------------------------------------------------------------
// sscheck_checker
// Port-level assertions for the sensor scratchpad checker.
// ----------------------------------------------------------------------------
`default_nettype none

module sscheck_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire sscheck_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transfer changed while stalled");

    a_no_sensor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == sscheck_pkg::STATUS_NO_SENSOR |->
            out_data.temperature_centi == '0 && out_data.raw_temperature == '0
            && out_data.computed_crc == '0 && out_data.config_writeback == '0)
        else $error("no-sensor result carries frame data");

    a_bad_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != sscheck_pkg::STATUS_OK |->
            out_data.temperature_centi == '0)
        else $error("temperature given without a good CRC");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status == sscheck_pkg::STATUS_OK
            || out_data.status == sscheck_pkg::STATUS_CRC_BAD
            || out_data.status == sscheck_pkg::STATUS_NO_SENSOR)
        else $error("illegal status code");

    a_delay_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.conversion_delay_ms == 10'd94
            || out_data.conversion_delay_ms == 10'd188
            || out_data.conversion_delay_ms == 10'd375
            || out_data.conversion_delay_ms == 10'd750)
        else $error("conversion delay out of table");

endmodule

bind sensor_scratchpad_checker sscheck_checker u_sscheck_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ----- tb/sensor_scratchpad_checker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_scratchpad_checker_tb
// Drives scratchpad frames through the checker and scores every reading
// against an in-bench model of the frame CRC, the raw assembly and the scale
// conversion. Directed frames, a scale/resolution sweep, a backpressure burst
// and random traffic, with random gaps on input and output.
// ----------------------------------------------------------------------------

module sensor_scratchpad_checker_tb;

    localparam int         FRAME_LEN      = 9;
    localparam logic [7:0] CRC8_POLY      = 8'h8C;
    localparam logic [1:0] SCALE_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         RANDOM_ITEMS   = 300;
    localparam int         MAX_REPORTS    = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    sscheck_pkg::in_item_t  in_data;
    logic                   out_valid;
    logic                   out_ready;
    sscheck_pkg::out_item_t out_data;
    logic                   cfg_write;
    logic                   cfg_index;
    logic [1:0]             cfg_data;

    sensor_scratchpad_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // reading model state
    int         frame_pos;
    logic [7:0] crc_run;
    logic [7:0] hold_lo;
    logic [7:0] hold_hi;
    logic [7:0] hold_ah;
    logic [7:0] hold_al;
    logic [7:0] hold_cfg;
    logic [1:0] scale_reg;
    logic [1:0] res_reg;

    sscheck_pkg::out_item_t expected_readings [$];

    int  mismatches;
    int  n_in_transfers;
    int  results_seen;
    int  n_ok;
    int  n_crc_bad;
    int  n_no_sensor;
    int  idle_cycles;
    bit  idle_on;
    bit  stall_on;
    bit  stall_heavy;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        repeat (8)
        begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [9:0] conv_delay(input logic [1:0] r);
        case (r)
            2'd0:    return 10'd94;
            2'd1:    return 10'd188;
            2'd2:    return 10'd375;
            default: return 10'd750;
        endcase
    endfunction

    function automatic void track_transfer(input sscheck_pkg::in_item_t it);
        sscheck_pkg::out_item_t r;
        logic signed [15:0]     raw;
        int                     rv;
        int                     centi;
        r = '0;
        if (it.command == sscheck_pkg::CMD_PRESENCE)
        begin
            frame_pos = 0;
            crc_run   = '0;
            if (!it.sensor_present)
            begin
                r.status              = sscheck_pkg::STATUS_NO_SENSOR;
                r.conversion_delay_ms = conv_delay(res_reg);
                expected_readings.push_back(r);
            end
        end
        else if (frame_pos < FRAME_LEN - 1)
        begin
            case (frame_pos)
                0: hold_lo  = it.data_byte;
                1: hold_hi  = it.data_byte;
                2: hold_ah  = it.data_byte;
                3: hold_al  = it.data_byte;
                4: hold_cfg = it.data_byte;
                default: ;
            endcase
            crc_run = crc_step(crc_run, it.data_byte);
            frame_pos++;
        end
        else
        begin
            raw   = {hold_hi, hold_lo};
            rv    = raw;
            centi = 0;
            if (crc_run == it.data_byte)
            begin
                case (scale_reg)
                    sscheck_pkg::SCALE_FAHRENHEIT: centi = ((rv * 45) >>> 2) + 3200;
                    sscheck_pkg::SCALE_KELVIN:     centi = ((rv * 25) >>> 2) + 27315;
                    default:                       centi = (rv * 25) >>> 2;
                endcase
            end
            r.status              = (crc_run == it.data_byte) ? sscheck_pkg::STATUS_OK
                                                              : sscheck_pkg::STATUS_CRC_BAD;
            r.temperature_centi   = 20'(centi);
            r.raw_temperature     = raw;
            r.alarm_high          = hold_ah;
            r.alarm_low           = hold_al;
            r.config_writeback    = {hold_cfg[7], res_reg, hold_cfg[4:0]};
            r.conversion_delay_ms = conv_delay(res_reg);
            r.computed_crc        = crc_run;
            expected_readings.push_back(r);
            frame_pos = 0;
            crc_run   = '0;
        end
    endfunction

    function automatic int pick_len();
        int x;
        x = $urandom_range(0, 99);
        if (x < 75)
            return $urandom_range(1, 3);
        else if (x < 94)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] pick_raw();
        logic [15:0] corners [6] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                                     16'h0001, 16'hFFFE};
        if ($urandom_range(0, 9) == 0)
            return corners[$urandom_range(0, 5)];
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_item(input sscheck_pkg::in_item_t it);
        int gap;
        gap = (idle_on && $urandom_range(0, 1)) ? pick_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        track_transfer(it);
        n_in_transfers++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        sscheck_pkg::in_item_t it;
        it.command        = sscheck_pkg::CMD_BYTE;
        it.data_byte      = b;
        it.sensor_present = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_presence(input logic present);
        sscheck_pkg::in_item_t it;
        it.command        = sscheck_pkg::CMD_PRESENCE;
        it.data_byte      = 8'($urandom_range(0, 255));
        it.sensor_present = present;
        send_item(it);
    endtask

    task automatic send_frame(input logic [15:0] raw, input bit with_presence,
                              input bit corrupt);
        logic [7:0] bytes [FRAME_LEN];
        logic [7:0] crc;
        bytes[0] = raw[7:0];
        bytes[1] = raw[15:8];
        for (int i = 2; i < FRAME_LEN - 1; i++)
            bytes[i] = 8'($urandom_range(0, 255));
        crc = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++)
            crc = crc_step(crc, bytes[i]);
        bytes[FRAME_LEN - 1] = corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc;
        if (with_presence)
            send_presence(1'b1);
        for (int i = 0; i < FRAME_LEN; i++)
            send_byte(bytes[i]);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == sscheck_pkg::REG_TEMP_SCALE)
            scale_reg = val;
        else
            res_reg = val;
    endtask

    task automatic configure(input logic [1:0] s, input logic [1:0] r);
        wait_drained();
        write_reg(sscheck_pkg::REG_TEMP_SCALE, s);
        write_reg(sscheck_pkg::REG_RESOLUTION, r);
    endtask

    // reset config: extremes of raw, frame with no presence, missing sensor, bad CRC
    task automatic test_directed_frames();
        send_frame(16'h8000, 1'b1, 1'b0);
        send_frame(16'h7FFF, 1'b0, 1'b0);
        send_presence(1'b0);
        send_frame(16'hFFFF, 1'b1, 1'b1);
    endtask

    task automatic test_scale_and_resolution();
        logic [1:0]  scales [8] = '{sscheck_pkg::SCALE_CELSIUS, sscheck_pkg::SCALE_FAHRENHEIT,
                                    sscheck_pkg::SCALE_KELVIN, SCALE_UNUSED,
                                    sscheck_pkg::SCALE_CELSIUS, sscheck_pkg::SCALE_FAHRENHEIT,
                                    sscheck_pkg::SCALE_KELVIN, SCALE_UNUSED};
        logic [1:0]  resols [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2};
        logic [15:0] raws   [8] = '{16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001,
                                    16'hFFF8, 16'h8000, 16'hFC90, 16'h7FFF};
        for (int i = 0; i < 8; i++)
        begin
            configure(scales[i], resols[i]);
            send_frame(raws[i], 1'b1, 1'b0);
            send_presence(1'b0);
        end
    endtask

    task automatic test_backpressure_burst();
        idle_on     = 1'b0;
        stall_heavy = 1'b1;
        repeat (3)
        begin
            send_frame(pick_raw(), 1'b1, 1'b0);
            repeat (3) send_presence(1'b0);
        end
        wait_drained();
        idle_on     = 1'b1;
        stall_heavy = 1'b0;
    endtask

    task automatic test_random_traffic();
        int                    in_start;
        int                    seg;
        int                    kind;
        sscheck_pkg::in_item_t it;
        in_start = n_in_transfers;
        seg      = 0;
        while (n_in_transfers - in_start < RANDOM_ITEMS)
        begin
            if (seg % 8 == 0)
            begin
                idle_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 1))
                    configure(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            end
            seg++;
            kind = $urandom_range(0, 99);
            if (kind < 62)
                send_frame(pick_raw(), 1'b1, 1'b0);
            else if (kind < 72)
                send_frame(pick_raw(), 1'b1, 1'b1);
            else if (kind < 80)
                send_presence(1'b0);
            else if (kind < 86)
                send_frame(pick_raw(), 1'b0, 1'b0);
            else if (kind < 93)
            begin
                // frame cut short by a new presence report
                send_presence(1'b1);
                repeat ($urandom_range(0, FRAME_LEN - 1))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    it.command        = 1'($urandom_range(0, 1));
                    it.data_byte      = 8'($urandom_range(0, 255));
                    it.sensor_present = 1'($urandom_range(0, 1));
                    send_item(it);
                end
            end
        end
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    initial
    begin
        int hold;
        out_ready = 1'b0;
        hold      = 0;
        forever
        begin
            @(negedge clk);
            if (stall_on && hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (stall_on && $urandom_range(0, 99) < (stall_heavy ? 70 : 25))
                    hold = pick_len();
            end
        end
    end

    task automatic cmp_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        sscheck_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            case (out_data.status)
                sscheck_pkg::STATUS_OK:        n_ok++;
                sscheck_pkg::STATUS_CRC_BAD:   n_crc_bad++;
                sscheck_pkg::STATUS_NO_SENSOR: n_no_sensor++;
                default: ;
            endcase
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected transfer: expected none, actual status %0d",
                             $time, out_data.status);
            end
            else
            begin
                want = expected_readings.pop_front();
                cmp_field("status", want.status, out_data.status);
                cmp_field("temperature_centi", $signed(want.temperature_centi),
                          $signed(out_data.temperature_centi));
                cmp_field("raw_temperature", $signed(want.raw_temperature),
                          $signed(out_data.raw_temperature));
                cmp_field("alarm_high", want.alarm_high, out_data.alarm_high);
                cmp_field("alarm_low", want.alarm_low, out_data.alarm_low);
                cmp_field("config_writeback", want.config_writeback, out_data.config_writeback);
                cmp_field("conversion_delay_ms", want.conversion_delay_ms,
                          out_data.conversion_delay_ms);
                cmp_field("computed_crc", want.computed_crc, out_data.computed_crc);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d readings outstanding",
                         $time, idle_cycles, expected_readings.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_write      = 1'b0;
        cfg_index      = sscheck_pkg::REG_TEMP_SCALE;
        cfg_data       = '0;
        idle_on        = 1'b1;
        stall_on       = 1'b1;
        stall_heavy    = 1'b0;
        mismatches     = 0;
        n_in_transfers = 0;
        results_seen   = 0;
        n_ok           = 0;
        n_crc_bad      = 0;
        n_no_sensor    = 0;
        idle_cycles    = 0;
        frame_pos      = 0;
        crc_run        = '0;
        hold_lo        = '0;
        hold_hi        = '0;
        hold_ah        = '0;
        hold_al        = '0;
        hold_cfg       = '0;
        scale_reg      = sscheck_pkg::SCALE_CELSIUS;
        res_reg        = sscheck_pkg::RESOLUTION_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_scale_and_resolution();
        test_backpressure_burst();
        test_random_traffic();

        wait_drained();
        repeat (10) @(posedge clk);
        $display("%0d input transfers, %0d readings: %0d ok, %0d crc mismatch, %0d no sensor",
                 n_in_transfers, results_seen, n_ok, n_crc_bad, n_no_sensor);
        $display("all scales incl. the unused code and all four resolutions were exercised");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
